// ===== hdl/lxrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lxrd_pkg
// Shared types and constants for the length/XOR response deframer.
// ----------------------------------------------------------------------------
package lxrd_pkg;

   localparam int          INDEX_SPAN   = 1024;     // payload_index holds 10 bits
   localparam logic [10:0] CAP_RESET    = 11'd1024;
   localparam logic [7:0]  SW1_EXPECTED = 8'h90;
   localparam logic [7:0]  SW2_EXPECTED = 8'h00;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_LEN_LO  = 6'b000010,
      PH_PAYLOAD = 6'b000100,
      PH_SW1     = 6'b001000,
      PH_SW2     = 6'b010000,
      PH_CHECK   = 6'b100000
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_XOR_BAD   = 2'd1,
      ST_SW_BAD    = 2'd2,
      ST_LEN_SHORT = 2'd3
   } status_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  payload_byte;
      logic [9:0]  payload_index;
      status_type  frame_status;
      logic [10:0] kept_length;
   } rsp_item_type;

endpackage

// ===== hdl/lxrd_req_if.sv =====
// ----------------------------------------------------------------------------
// lxrd_req_if
// Receive byte channel: valid/ready with one link byte and a start mark.
// ----------------------------------------------------------------------------
interface lxrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== hdl/lxrd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lxrd_rsp_if
// Result channel: valid/ready with a kept payload byte or a frame status.
// ----------------------------------------------------------------------------
interface lxrd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [9:0]  payload_index;
   logic [1:0]  frame_status;
   logic [10:0] kept_length;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output frame_status, output kept_length,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_index, input frame_status, input kept_length,
                   output ready);
endinterface

// ===== hdl/length_xor_response_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_xor_response_deframer_core
// Deframes length-prefixed response frames with a trailing XOR check byte.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_chan in   valid/ready   rx_byte[7:0], frame_start
//  rsp_chan out  valid/ready   result_kind, payload_byte[7:0], payload_index[9:0],
//                              frame_status[1:0], kept_length[10:0]
//  csr_*    in   write enable  csr_wdata[10:0] = buffer_capacity
//
//  One byte is taken per cycle while ready is high and parsed in the cycle it is
//  accepted; its result is registered in the output register, or the skid slot if it is held.
//  The result side holds an output register and one skid slot, so req_chan
//  keeps taking bytes while a result waits; ready drops only when both are full.
//  Reset (synchronous, active high) returns to idle and sets capacity to 1024.
// ----------------------------------------------------------------------------
module length_xor_response_deframer_core #(
   parameter int BUFFER_BYTES = 1024,
   parameter int CHECK_BYTES  = 1
) (
   input  logic        clock,
   input  logic        reset,
   lxrd_req_if.sink    req_chan,
   lxrd_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);

   logic                   accept;
   logic                   space;
   logic                   res_valid;
   lxrd_pkg::rsp_item_type res_item;
   lxrd_pkg::rsp_item_type out_item;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   lxrd_parser #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .CHECK_BYTES  (CHECK_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_chan.rx_byte),
      .frame_start (req_chan.frame_start),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .res_valid   (res_valid),
      .res_item    (res_item)
   );

   lxrd_rsp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res_item),
      .space     (space),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (out_item)
   );

   assign rsp_chan.result_kind   = out_item.result_kind;
   assign rsp_chan.payload_byte  = out_item.payload_byte;
   assign rsp_chan.payload_index = out_item.payload_index;
   assign rsp_chan.frame_status  = out_item.frame_status;
   assign rsp_chan.kept_length   = out_item.kept_length;

endmodule

// ===== hdl/lxrd_parser.sv =====
// ----------------------------------------------------------------------------
// lxrd_parser
// Frame parser: phase tracking, running XOR, payload indexing, final status.
// ----------------------------------------------------------------------------
module lxrd_parser #(
   parameter int BUFFER_BYTES = 1024,
   parameter int CHECK_BYTES  = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic                   frame_start,
   input  logic                   csr_we,
   input  logic [10:0]            csr_wdata,
   output logic                   res_valid,
   output lxrd_pkg::rsp_item_type res_item
);

   localparam int CAP_LIMIT = (BUFFER_BYTES < lxrd_pkg::INDEX_SPAN) ?
                              BUFFER_BYTES : lxrd_pkg::INDEX_SPAN;
   localparam int CHK_W     = $clog2(CHECK_BYTES + 1);

   lxrd_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [10:0]         cap_ff, cap_in;
   logic [7:0]          len_hi_ff, len_hi_in;
   logic [15:0]         remaining_ff, remaining_in;
   logic [15:0]         position_ff, position_in;
   logic [7:0]          xor_ff, xor_in;
   logic [7:0]          sw1_ff, sw1_in;
   logic [7:0]          sw2_ff, sw2_in;
   logic [10:0]         kept_ff, kept_in;
   logic [CHK_W-1:0]    chk_ff, chk_in;
   logic [10:0]         eff_cap;
   logic                len_short;

   assign eff_cap   = (cap_ff > 11'(CAP_LIMIT)) ? 11'(CAP_LIMIT) : cap_ff;
   assign len_short = (len_hi_ff == 8'd0) && (rx_byte[7:1] == 7'd0);
   assign cap_in    = csr_we ? csr_wdata : cap_ff;

   always_comb begin
      phase_in     = phase_ff;
      len_hi_in    = len_hi_ff;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      xor_in       = xor_ff;
      sw1_in       = sw1_ff;
      sw2_in       = sw2_ff;
      kept_in      = kept_ff;
      chk_in       = chk_ff;
      res_valid    = 1'b0;
      res_item     = '0;
      phase_cur    = frame_start ? lxrd_pkg::PH_IDLE : phase_ff;
      if (accept) begin
         unique case (phase_cur)
            lxrd_pkg::PH_IDLE: begin
               len_hi_in    = rx_byte;
               xor_in       = rx_byte;
               kept_in      = 11'd0;
               position_in  = 16'd0;
               remaining_in = 16'd0;
               phase_in     = lxrd_pkg::PH_LEN_LO;
            end
            lxrd_pkg::PH_LEN_LO: begin
               xor_in = xor_ff ^ rx_byte;
               if (len_short) begin
                  // flag a runt length at once and drop back to idle
                  phase_in              = lxrd_pkg::PH_IDLE;
                  res_valid             = 1'b1;
                  res_item.result_kind  = lxrd_pkg::KIND_STATUS;
                  res_item.frame_status = lxrd_pkg::ST_LEN_SHORT;
               end else begin
                  remaining_in = {len_hi_ff, rx_byte} - 16'd2;
                  phase_in     = (remaining_in != 16'd0) ? lxrd_pkg::PH_PAYLOAD
                                                         : lxrd_pkg::PH_SW1;
               end
            end
            lxrd_pkg::PH_PAYLOAD: begin
               xor_in = xor_ff ^ rx_byte;
               if (position_ff < {5'd0, eff_cap}) begin
                  res_valid              = 1'b1;
                  res_item.result_kind   = lxrd_pkg::KIND_PAYLOAD;
                  res_item.payload_byte  = rx_byte;
                  res_item.payload_index = position_ff[9:0];
                  kept_in                = kept_ff + 11'd1;
               end
               position_in  = position_ff + 16'd1;
               remaining_in = remaining_ff - 16'd1;
               if (remaining_ff == 16'd1) begin
                  phase_in = lxrd_pkg::PH_SW1;
               end
            end
            lxrd_pkg::PH_SW1: begin
               sw1_in   = rx_byte;
               xor_in   = xor_ff ^ rx_byte;
               phase_in = lxrd_pkg::PH_SW2;
            end
            lxrd_pkg::PH_SW2: begin
               sw2_in   = rx_byte;
               xor_in   = xor_ff ^ rx_byte;
               chk_in   = CHK_W'(CHECK_BYTES);
               phase_in = lxrd_pkg::PH_CHECK;
            end
            lxrd_pkg::PH_CHECK: begin
               if (chk_ff > CHK_W'(1)) begin
                  // skip leading check bytes, only the last one counts
                  chk_in = chk_ff - CHK_W'(1);
               end else begin
                  chk_in               = '0;
                  phase_in             = lxrd_pkg::PH_IDLE;
                  res_valid            = 1'b1;
                  res_item.result_kind = lxrd_pkg::KIND_STATUS;
                  res_item.kept_length = kept_ff;
                  if (rx_byte != xor_ff) begin
                     res_item.frame_status = lxrd_pkg::ST_XOR_BAD;
                  end else if (sw1_ff != lxrd_pkg::SW1_EXPECTED ||
                               sw2_ff != lxrd_pkg::SW2_EXPECTED) begin
                     res_item.frame_status = lxrd_pkg::ST_SW_BAD;
                  end else begin
                     res_item.frame_status = lxrd_pkg::ST_OK;
                  end
               end
            end
            default: begin
               phase_in = lxrd_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lxrd_pkg::PH_IDLE;
         cap_ff       <= lxrd_pkg::CAP_RESET;
         len_hi_ff    <= '0;
         remaining_ff <= '0;
         position_ff  <= '0;
         xor_ff       <= '0;
         sw1_ff       <= '0;
         sw2_ff       <= '0;
         kept_ff      <= '0;
         chk_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         cap_ff       <= cap_in;
         len_hi_ff    <= len_hi_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         xor_ff       <= xor_in;
         sw1_ff       <= sw1_in;
         sw2_ff       <= sw2_in;
         kept_ff      <= kept_in;
         chk_ff       <= chk_in;
      end
   end

   a_index_in_capacity: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_item.result_kind == lxrd_pkg::KIND_PAYLOAD)
         |-> ({1'b0, res_item.payload_index} < eff_cap))
      else $error("payload index beyond capacity");

   a_kept_bounded: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= 11'(CAP_LIMIT))
      else $error("kept count beyond capacity limit");

   a_short_len_empty: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_item.frame_status == lxrd_pkg::ST_LEN_SHORT)
         |-> (res_item.kept_length == 11'd0 && phase_in == lxrd_pkg::PH_IDLE))
      else $error("short length result carries a count or keeps the frame open");

   a_kept_tracks_position: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lxrd_pkg::PH_PAYLOAD) |-> ({5'd0, kept_ff} <= position_ff))
      else $error("kept count ahead of payload position");

endmodule

// ===== hdl/lxrd_rsp_skid.sv =====
// ----------------------------------------------------------------------------
// lxrd_rsp_skid
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module lxrd_rsp_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lxrd_pkg::rsp_item_type push_item,
   output logic                   space,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lxrd_pkg::rsp_item_type out_item
);

   lxrd_pkg::rsp_item_type head_ff, head_in;
   lxrd_pkg::rsp_item_type skid_ff, skid_in;
   logic [1:0]             count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = head_ff;
   assign space     = (count_ff != 2'd2);
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_item;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (pop && push) begin
               head_in = push_item;
            end else if (pop) begin
               count_in = 2'd0;
            end else if (push) begin
               skid_in  = push_item;
               count_in = 2'd2;
            end
         end
         default: begin
            // full: advance the skid item when the head leaves
            if (pop) begin
               head_in  = skid_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("item pushed into full result buffer");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> (count_ff == 2'd2 && $stable(skid_ff)))
      else $error("full result buffer lost an item");

endmodule

// ===== tb/sv/lxrd_deframe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxrd_deframe_checker
// Watches the byte, result and register ports of the deframer, tracks the
// frame state byte by byte and compares every result with the oldest
// predicted one. Hands the mismatch count and the outstanding count out.
// ----------------------------------------------------------------------------
module lxrd_deframe_checker #(
   parameter int BUFFER_BYTES = 1024,
   parameter int CHECK_BYTES  = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_byte,
   input  logic        req_start,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_kind,
   input  logic [7:0]  rsp_byte,
   input  logic [9:0]  rsp_index,
   input  logic [1:0]  rsp_status,
   input  logic [10:0] rsp_kept,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   output int          mismatch_count,
   output int          pending
);

   lxrd_pkg::rsp_item_type expected_results[$];

   lxrd_pkg::phase_type frame_phase;
   logic [10:0]         capacity;
   logic [7:0]          length_high;
   logic [7:0]          running_xor;
   logic [7:0]          status_hi;
   logic [7:0]          status_lo;
   logic [15:0]         bytes_due;
   logic [15:0]         buffer_pos;
   logic [10:0]         kept_count;

   // Advance the frame state by one received byte and queue any result it causes.
   function void deframe_byte(input logic [7:0] b, input logic start);
      logic [15:0]            frame_len;
      int                     limit;
      lxrd_pkg::rsp_item_type r;
      r = '0;
      limit = int'(capacity);
      if (limit > BUFFER_BYTES) limit = BUFFER_BYTES;
      if (limit > lxrd_pkg::INDEX_SPAN) limit = lxrd_pkg::INDEX_SPAN;
      if (start) frame_phase = lxrd_pkg::PH_IDLE;
      case (frame_phase)
         lxrd_pkg::PH_IDLE: begin
            length_high = b;
            running_xor = b;
            kept_count  = '0;
            buffer_pos  = '0;
            bytes_due   = '0;
            frame_phase = lxrd_pkg::PH_LEN_LO;
         end
         lxrd_pkg::PH_LEN_LO: begin
            frame_len = {length_high, b};
            running_xor = running_xor ^ b;
            if (frame_len < 16'd2) begin
               frame_phase = lxrd_pkg::PH_IDLE;
               r.result_kind = lxrd_pkg::KIND_STATUS;
               r.frame_status = lxrd_pkg::ST_LEN_SHORT;
               expected_results.push_back(r);
            end else begin
               bytes_due = frame_len - 16'd2;
               if (bytes_due != 0) frame_phase = lxrd_pkg::PH_PAYLOAD;
               else frame_phase = lxrd_pkg::PH_SW1;
            end
         end
         lxrd_pkg::PH_PAYLOAD: begin
            running_xor = running_xor ^ b;
            if (int'(buffer_pos) < limit) begin
               r.result_kind = lxrd_pkg::KIND_PAYLOAD;
               r.payload_byte = b;
               r.payload_index = buffer_pos[9:0];
               expected_results.push_back(r);
               kept_count = kept_count + 11'd1;
            end
            buffer_pos = buffer_pos + 16'd1;
            bytes_due = bytes_due - 16'd1;
            if (bytes_due == 0) frame_phase = lxrd_pkg::PH_SW1;
         end
         lxrd_pkg::PH_SW1: begin
            status_hi = b;
            running_xor = running_xor ^ b;
            frame_phase = lxrd_pkg::PH_SW2;
         end
         lxrd_pkg::PH_SW2: begin
            status_lo = b;
            running_xor = running_xor ^ b;
            bytes_due = 16'(CHECK_BYTES);
            frame_phase = lxrd_pkg::PH_CHECK;
         end
         lxrd_pkg::PH_CHECK: begin
            // only the last check byte counts; earlier ones are skipped
            if (bytes_due > 16'd1) begin
               bytes_due = bytes_due - 16'd1;
            end else begin
               bytes_due = '0;
               frame_phase = lxrd_pkg::PH_IDLE;
               r.result_kind = lxrd_pkg::KIND_STATUS;
               r.kept_length = kept_count;
               if (b != running_xor) r.frame_status = lxrd_pkg::ST_XOR_BAD;
               else if (status_hi != lxrd_pkg::SW1_EXPECTED ||
                        status_lo != lxrd_pkg::SW2_EXPECTED)
                  r.frame_status = lxrd_pkg::ST_SW_BAD;
               else r.frame_status = lxrd_pkg::ST_OK;
               expected_results.push_back(r);
            end
         end
         default: frame_phase = lxrd_pkg::PH_IDLE;
      endcase
   endfunction

   function automatic bit field_bad(input string name, input logic [10:0] want,
                                    input logic [10:0] got);
      if (want !== got)
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      return want !== got;
   endfunction

   function void check_result();
      lxrd_pkg::rsp_item_type want;
      bit                     bad;
      if (expected_results.size() == 0) begin
         $display("%0t ns: unexpected result kind %0d byte %0d index %0d status %0d kept %0d",
                  $time, rsp_kind, rsp_byte, rsp_index, rsp_status, rsp_kept);
         mismatch_count++;
      end else begin
         want = expected_results.pop_front();
         bad = field_bad("result_kind", 11'(want.result_kind), 11'(rsp_kind))
             | field_bad("payload_byte", 11'(want.payload_byte), 11'(rsp_byte))
             | field_bad("payload_index", 11'(want.payload_index), 11'(rsp_index))
             | field_bad("frame_status", 11'(want.frame_status), 11'(rsp_status))
             | field_bad("kept_length", want.kept_length, rsp_kept);
         if (bad) mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         frame_phase = lxrd_pkg::PH_IDLE;
         capacity    = lxrd_pkg::CAP_RESET;
         length_high = '0;
         running_xor = '0;
         status_hi   = '0;
         status_lo   = '0;
         bytes_due   = '0;
         buffer_pos  = '0;
         kept_count  = '0;
         pending <= 0;
      end else begin
         // drain first: a result never belongs to the byte taken at the same edge
         if (rsp_valid && rsp_ready) check_result();
         if (req_valid && req_ready) deframe_byte(req_byte, req_start);
         if (csr_we) capacity = csr_wdata;
         pending <= expected_results.size();
      end
   end

endmodule

// ===== tb/sv/length_xor_response_deframer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_xor_response_deframer_core_test
// Feeds the deframer with directed and random response frames (good, bad
// check byte, bad status word, short length, cut short, line noise) under
// several buffer capacities, with random gaps and result back-pressure.
// ----------------------------------------------------------------------------
module length_xor_response_deframer_core_test;

   localparam int BUFFER_BYTES = 1024;
   localparam int CHECK_BYTES  = 1;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [10:0] csr_wdata;
   int          mismatch_count;
   int          pending_results;
   int          sent_bytes;
   bit          gaps_on;
   bit          stalls_on;
   bit          link_idle;

   lxrd_req_if req_chan();
   lxrd_rsp_if rsp_chan();

   length_xor_response_deframer_core #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .CHECK_BYTES (CHECK_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lxrd_deframe_checker #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .CHECK_BYTES (CHECK_BYTES)
   ) frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_byte       (req_chan.rx_byte),
      .req_start      (req_chan.frame_start),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_kind       (rsp_chan.result_kind),
      .rsp_byte       (rsp_chan.payload_byte),
      .rsp_index      (rsp_chan.payload_index),
      .rsp_status     (rsp_chan.frame_status),
      .rsp_kept       (rsp_chan.kept_length),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending        (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: ready with random stall bursts.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Present one item and hold it until taken; sometimes idle afterwards.
   task automatic send_byte(input logic [7:0] b, input logic start);
      req_chan.valid       <= 1'b1;
      req_chan.rx_byte     <= b;
      req_chan.frame_start <= start;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sent_bytes++;
      if (gaps_on && $urandom_range(0, 11) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic wait_results_drained();
      int unsigned guard;
      req_chan.valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_results != 0 && guard < 4000);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [10:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Build a frame for plen payload bytes; send only its first keep_bytes
   // when that is nonzero and shorter than the frame.
   task automatic send_frame(input int unsigned plen, input logic mark, input bit bad_xor,
                             input bit good_sw, input int unsigned keep_bytes);
      logic [7:0]  frame_bytes[$];
      logic [15:0] frame_len;
      logic [7:0]  sum;
      int unsigned keep;
      frame_len = 16'(plen + 2);
      frame_bytes.push_back(frame_len[15:8]);
      frame_bytes.push_back(frame_len[7:0]);
      repeat (plen) frame_bytes.push_back(8'($urandom));
      if (good_sw) begin
         frame_bytes.push_back(lxrd_pkg::SW1_EXPECTED);
         frame_bytes.push_back(lxrd_pkg::SW2_EXPECTED);
      end else begin
         frame_bytes.push_back(8'($urandom));
         frame_bytes.push_back(8'($urandom));
      end
      sum = '0;
      foreach (frame_bytes[i]) sum ^= frame_bytes[i];
      if (bad_xor) sum ^= 8'($urandom_range(1, 255));
      frame_bytes.push_back(sum);
      keep = frame_bytes.size();
      if (keep_bytes != 0 && keep_bytes < keep) keep = keep_bytes;
      for (int i = 0; i < keep; i++) send_byte(frame_bytes[i], (i == 0) ? mark : 1'b0);
      link_idle = (keep == frame_bytes.size());
   endtask

   task automatic send_short(input logic mark);
      send_byte(8'h00, mark);
      send_byte(8'($urandom_range(0, 1)), 1'b0);
      link_idle = 1'b1;
   endtask

   function automatic int unsigned pick_payload_len();
      if ($urandom_range(0, 59) == 0) return $urandom_range(250, 300);
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 40);
      return $urandom_range(0, 10);
   endfunction

   task automatic random_traffic();
      int unsigned pick;
      int unsigned plen;
      logic        mark;
      pick = $urandom_range(0, 99);
      plen = pick_payload_len();
      // a frame may omit the start mark only when the deframer sits idle
      mark = link_idle ? 1'($urandom_range(0, 1)) : 1'b1;
      if (pick < 72) begin
         send_frame(plen, mark, $urandom_range(0, 5) == 0, $urandom_range(0, 3) != 0, 0);
      end else if (pick < 80) begin
         send_frame(plen, 1'b1, 1'b0, 1'b1, $urandom_range(1, plen + 4));
      end else if (pick < 88) begin
         send_short(mark);
      end else if (pick < 97) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
         link_idle = 1'b0;
      end else begin
         wait_results_drained();
      end
   endtask

   task automatic run_phase(input logic [10:0] cap, input int unsigned budget);
      int unsigned target;
      wait_results_drained();
      write_capacity(cap);
      target = sent_bytes + budget;
      while (sent_bytes < target) random_traffic();
   endtask

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.rx_byte     <= '0;
      req_chan.frame_start <= 1'b0;
      csr_we               <= 1'b0;
      csr_wdata            <= '0;
      sent_bytes = 0;
      gaps_on    = 1'b1;
      stalls_on  = 1'b1;
      link_idle  = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: short lengths, unmarked first byte, empty payload,
      // both faults, bad status word, abandoned frame, plain good frame
      send_short(1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_frame(0, 1'b1, 1'b0, 1'b1, 0);
      send_frame(2, 1'b1, 1'b1, 1'b0, 0);
      send_frame(3, 1'b0, 1'b0, 1'b0, 0);
      send_frame(5, 1'b1, 1'b0, 1'b1, 3);
      send_frame(1, 1'b1, 1'b0, 1'b1, 0);

      run_phase(11'd0, 110);
      run_phase(11'd1, 110);
      run_phase(11'h7FF, 110);
      run_phase(11'($urandom_range(2, 40)), 140);
      run_phase(lxrd_pkg::CAP_RESET, 140);
      run_phase(11'($urandom_range(0, 1024)), 140);

      // closing stretch without random gaps or result stalls
      gaps_on = 1'b0;
      stalls_on <= 1'b0;
      run_phase(11'($urandom_range(3, 12)), 100);

      wait_results_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
